### rtl/ubsd_pkg.sv
package ubsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// sequence length of the open code point, by lead byte
	typedef enum logic [1:0] {
		LEN_ONE   = 2'd0,
		LEN_TWO   = 2'd1,
		LEN_THREE = 2'd2,
		LEN_FOUR  = 2'd3
	} len_class_t;

	localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;

	// smallest value that is not overlong for a given length
	function automatic logic [CP_W-1:0] min_for_class(input len_class_t cls);
		logic [CP_W-1:0] m;
		case (cls)
			LEN_TWO:   m = 21'h000080;
			LEN_THREE: m = 21'h000800;
			LEN_FOUR:  m = 21'h010000;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

### rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder.
// Byte channel: in_byte with byte_valid / byte_stall; a transaction completes
// at a rising edge with byte_valid high and byte_stall low.
// Code point channel: code_point with code_valid / code_stall, same rule.
// Each byte lands in an input register, is decoded by one level of logic
// against the sequence state, and any result goes into the output register.
// A result byte (ASCII, stray continuation, last byte of a sequence or a
// byte breaking a sequence) passes from the input register into the output
// register, which drives code_valid and code_point.
// Lead bytes only update state and give no result.
// Throughput: one byte per cycle while byte_stall stays low, set by the
// single decode step between the two registers; the output register lets a
// new byte enter while a result waits to be taken.
// When code_stall holds the output register full, a byte needing a result
// waits in the input register and byte_stall rises; bytes with no result
// (leads, inner continuations) still pass.
// 0xFFFD is returned for stray continuations, broken and overlong sequences.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// decoder to idle with no partial sequence.
module utf8_byte_stream_decoder
	import ubsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              code_valid,
	input  logic              code_stall,
	output logic [CP_W-1:0]   code_point
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [CP_W-1:0]   pv_q;
	logic [1:0]        rem_q;
	len_class_t        cls_q;

	logic              code_valid_q;
	logic [CP_W-1:0]   code_point_q;

	logic [CP_W-1:0]   pv_d;
	logic [1:0]        rem_d;
	len_class_t        cls_d;
	logic              emit;
	logic [CP_W-1:0]   emit_val;
	logic [CP_W-1:0]   shifted;
	logic              out_free;
	logic              advance;

	always_comb begin
		pv_d     = pv_q;
		rem_d    = rem_q;
		cls_d    = cls_q;
		emit     = 1'b0;
		emit_val = REPLACEMENT_CP;
		shifted  = {pv_q[CP_W-7:0], byte_s1[5:0]};
		if (rem_q == 2'd0) begin
			if (byte_s1 >= LEAD4_MIN) begin
				pv_d  = CP_W'(byte_s1[2:0]);
				rem_d = 2'd3;
				cls_d = LEN_FOUR;
			end else if (byte_s1 >= LEAD3_MIN) begin
				pv_d  = CP_W'(byte_s1[3:0]);
				rem_d = 2'd2;
				cls_d = LEN_THREE;
			end else if (byte_s1 >= LEAD2_MIN) begin
				pv_d  = CP_W'(byte_s1[4:0]);
				rem_d = 2'd1;
				cls_d = LEN_TWO;
			end else begin
				cls_d    = LEN_ONE;
				emit     = 1'b1;
				emit_val = (byte_s1 >= CONT_MIN) ? REPLACEMENT_CP : CP_W'(byte_s1);
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			// broken sequence: byte is consumed, not taken as a new lead
			pv_d  = '0;
			rem_d = 2'd0;
			cls_d = LEN_ONE;
			emit  = 1'b1;
		end else begin
			rem_d = rem_q - 2'd1;
			if (rem_q == 2'd1) begin
				pv_d     = '0;
				cls_d    = LEN_ONE;
				emit     = 1'b1;
				emit_val = (shifted < min_for_class(cls_q)) ? REPLACEMENT_CP : shifted;
			end else begin
				pv_d = shifted;
			end
		end
	end

	assign out_free   = !code_valid_q || !code_stall;
	assign advance    = valid_s1 && (!emit || out_free);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			rem_q <= 2'd0;
			cls_q <= LEN_ONE;
		end else if (advance) begin
			pv_q  <= pv_d;
			rem_q <= rem_d;
			cls_q <= cls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (out_free) begin
			code_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			code_point_q <= emit_val;
		end
	end

	assign code_valid = code_valid_q;
	assign code_point = code_point_q;

	// idle decoder never holds a multi-byte length
	a_idle_class: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 2'd0) |-> (cls_q == LEN_ONE))
		else $error("length class set while idle");

	// remaining count never exceeds what the lead announced
	a_rem_le_class: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q <= 2'(cls_q)))
		else $error("remaining count above length class");

	// stall only while a byte sits in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("byte_stall with empty input register");

	// a lead byte decoded while idle opens a sequence
	a_lead_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (rem_q == 2'd0) && (byte_s1 >= LEAD2_MIN)) |=> (rem_q != 2'd0))
		else $error("lead byte did not open a sequence");

endmodule

### tb/sv/testbench.sv
module testbench;
	import ubsd_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              code_valid;
	logic              code_stall = 1'b0;
	logic [CP_W-1:0]   code_point;

	// decoder state mirrored by the predictor
	logic [CP_W-1:0] seq_value;
	logic [1:0]      seq_left;
	len_class_t      seq_len;

	logic [CP_W-1:0] pending_cp[$];

	int  bytes_sent   = 0;
	int  cps_taken    = 0;
	int  fffd_seen    = 0;
	int  mismatches   = 0;
	int  stall_left   = 0;
	int  hold_cycles  = 0;
	bit  idle_in      = 1'b1;
	bit  idle_out     = 1'b1;

	utf8_byte_stream_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_point (code_point)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// returns 1 when the byte completes a code point
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output logic [CP_W-1:0] cp);
		logic [CP_W-1:0] floor_cp;
		cp = '0;
		if (seq_left == 2'd0) begin
			if (b >= LEAD4_MIN) begin
				seq_value = {18'd0, b[2:0]};
				seq_left  = 2'd3;
				seq_len   = LEN_FOUR;
				return 1'b0;
			end
			if (b >= LEAD3_MIN) begin
				seq_value = {17'd0, b[3:0]};
				seq_left  = 2'd2;
				seq_len   = LEN_THREE;
				return 1'b0;
			end
			if (b >= LEAD2_MIN) begin
				seq_value = {16'd0, b[4:0]};
				seq_left  = 2'd1;
				seq_len   = LEN_TWO;
				return 1'b0;
			end
			seq_len = LEN_ONE;
			cp = (b >= CONT_MIN) ? REPLACEMENT_CP : {13'd0, b};
			return 1'b1;
		end
		if (b[7:6] != 2'b10) begin
			// broken sequence: the byte is swallowed, not taken as a new lead
			seq_value = '0;
			seq_left  = 2'd0;
			seq_len   = LEN_ONE;
			cp = REPLACEMENT_CP;
			return 1'b1;
		end
		seq_value = {seq_value[CP_W-7:0], b[5:0]};
		seq_left  = seq_left - 2'd1;
		if (seq_left != 2'd0)
			return 1'b0;
		case (seq_len)
			LEN_TWO:   floor_cp = 21'h000080;
			LEN_THREE: floor_cp = 21'h000800;
			LEN_FOUR:  floor_cp = 21'h010000;
			default:   floor_cp = '0;
		endcase
		cp = (seq_value < floor_cp) ? REPLACEMENT_CP : seq_value;
		seq_value = '0;
		seq_len   = LEN_ONE;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		logic [CP_W-1:0] cp;
		gap = idle_in ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		do
			@(posedge clk);
		while (byte_stall);
		bytes_sent++;
		if (decode_byte(b, cp))
			pending_cp.push_back(cp);
	endtask

	task automatic send_bytes(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic wait_drained();
		// stop offering so the last byte is not taken again
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_cp.size() != 0)
			@(posedge clk);
		// lead bytes give no result but may still sit in the pipe
		repeat (4) @(posedge clk);
	endtask

	// lead of random length class, then the matching number of continuations
	task automatic send_valid_sequence();
		int len;
		logic [BYTE_W-1:0] lead;
		len = $urandom_range(1, 4);
		case (len)
			1:       lead = 8'($urandom_range(8'h00, 8'h7F));
			2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
			3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
			default: lead = 8'($urandom_range(8'hF0, 8'hFF));
		endcase
		send_byte(lead);
		repeat (len - 1)
			send_byte({2'b10, 6'($urandom)});
	endtask

	// lead, some continuations, then a byte that is not a continuation
	task automatic send_broken_sequence();
		int n;
		logic [BYTE_W-1:0] breaker;
		send_byte(8'($urandom_range(8'hC0, 8'hFF)));
		n = $urandom_range(0, 2);
		repeat (n)
			send_byte({2'b10, 6'($urandom)});
		do
			breaker = 8'($urandom);
		while (breaker[7:6] == 2'b10);
		send_byte(breaker);
	endtask

	task automatic test_directed();
		send_bytes('{8'h00, 8'h7F, 8'h80, 8'hBF});
		send_bytes('{8'hC2, 8'h80});
		send_bytes('{8'hC0, 8'h80});
		send_bytes('{8'hE0, 8'hA0, 8'h80});
		send_bytes('{8'hE0, 8'h80, 8'h80});
		send_bytes('{8'hF0, 8'h80, 8'h80, 8'h80});
		// lead above 0xF7 acts as a four-byte lead; gives the widest value
		send_bytes('{8'hFF, 8'hBF, 8'hBF, 8'hBF});
		send_bytes('{8'hC3, 8'h41});
		send_bytes('{8'hE2, 8'h82, 8'hF0});
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_in  = 1'b0;
		@(posedge clk);
		hold_cycles = 60;
		repeat (20)
			send_valid_sequence();
		wait_drained();
		idle_in = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (10)
			send_valid_sequence();
		wait_drained();
		repeat (10)
			send_valid_sequence();
	endtask

	task automatic test_random();
		int pick;
		int chunk;
		chunk = 0;
		while (bytes_sent < 1200) begin
			if (bytes_sent / 100 != chunk) begin
				chunk    = bytes_sent / 100;
				idle_in  = ($urandom_range(0, 3) != 0);
				idle_out = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_byte(8'($urandom));
			else if (pick == 1)
				send_broken_sequence();
			else
				send_valid_sequence();
		end
		idle_in  = 1'b1;
		idle_out = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			code_stall <= 1'b1;
			hold_cycles--;
		end else if (stall_left > 0) begin
			code_stall <= 1'b1;
			stall_left--;
		end else begin
			code_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && code_valid && !code_stall) begin
			cps_taken++;
			if (code_point == REPLACEMENT_CP)
				fffd_seen++;
			stall_left = idle_out ? $urandom_range(0, 4) : 0;
			if (pending_cp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected code point %h", code_point);
			end else if (code_point !== pending_cp[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("code point mismatch: expected %h got %h",
						pending_cp[0], code_point);
				void'(pending_cp.pop_front());
			end else begin
				void'(pending_cp.pop_front());
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		in_byte    = '0;
		seq_value  = '0;
		seq_left   = 2'd0;
		seq_len    = LEN_ONE;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();

		@(negedge clk);
		byte_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Decoded %0d bytes into %0d code points (%0d replacements),",
			bytes_sent, cps_taken, fffd_seen);
		$display("with random gaps, a long output hold and a full drain; %0d mismatches",
			mismatches + pending_cp.size());
		if (mismatches == 0 && pending_cp.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
